// ===== hw/rtl/snli_pkg.sv =====
// Shared types, register codes and constants for the shunting leaky integrator neuron.
package snli_pkg;

  localparam int unsigned MaxElementsDef = 1024;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_BETA  = 3'd1;
  localparam logic [2:0] REG_PHI   = 3'd2;
  localparam logic [2:0] REG_CHI   = 3'd3;
  localparam logic [2:0] REG_PSI   = 3'd4;
  localparam logic [2:0] REG_LEAK  = 3'd5;
  localparam logic [2:0] REG_AVG   = 3'd6;

  localparam logic [15:0] ALPHA_RST = 16'd0;
  localparam logic [15:0] GAIN_RST  = 16'd4096;
  localparam logic [15:0] LEAK_RST  = 16'd6554;

  localparam int unsigned CordicIters = 17;
  localparam logic [15:0] INV_TAN1    = 16'd42080;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] phi;
    logic signed [15:0] chi;
    logic signed [15:0] psi;
    logic [15:0]        leak;
    logic               avg;
  } cfg_t;

  function automatic logic [15:0] atan_lut(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30386;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/snli_fifo.sv =====
// Short register queue carrying finished tick records from the front to the back.
module snli_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/snli_front.sv =====
// Front end: accumulates channel sums and counts and emits one record per tick.
module snli_front #(
  parameter int unsigned SUM_W = 27,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned MAX_ELEMENTS = 1024,
  localparam int unsigned REC_W = 3 * (SUM_W + CNT_W)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic signed [15:0] exc_value_i,
  input  logic               exc_valid_i,
  input  logic signed [15:0] inh_value_i,
  input  logic               inh_valid_i,
  input  logic signed [15:0] shunt_value_i,
  input  logic               shunt_valid_i,
  input  logic               tick_last_i,
  output logic               push_o,
  output logic [REC_W-1:0]   rec_o
);
  logic signed [SUM_W-1:0] esum_q, esum_d, isum_q, isum_d, ssum_q, ssum_d;
  logic [CNT_W-1:0]        ecnt_q, ecnt_d, icnt_q, icnt_d, scnt_q, scnt_d;
  logic                    e_take, i_take, s_take;

  assign e_take = accept_i && exc_valid_i && (ecnt_q < CNT_W'(MAX_ELEMENTS));
  assign i_take = accept_i && inh_valid_i && (icnt_q < CNT_W'(MAX_ELEMENTS));
  assign s_take = accept_i && shunt_valid_i && (scnt_q < CNT_W'(MAX_ELEMENTS));

  always_comb begin
    esum_d = esum_q;
    isum_d = isum_q;
    ssum_d = ssum_q;
    ecnt_d = ecnt_q;
    icnt_d = icnt_q;
    scnt_d = scnt_q;
    if (e_take) begin
      esum_d = esum_q + SUM_W'(exc_value_i);
      ecnt_d = ecnt_q + 1'b1;
    end
    if (i_take) begin
      isum_d = isum_q + SUM_W'(inh_value_i);
      icnt_d = icnt_q + 1'b1;
    end
    if (s_take) begin
      ssum_d = ssum_q + SUM_W'(shunt_value_i);
      scnt_d = scnt_q + 1'b1;
    end
  end

  assign push_o = accept_i && tick_last_i;
  assign rec_o  = {esum_d, isum_d, ssum_d, ecnt_d, icnt_d, scnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      isum_q <= '0;
      ssum_q <= '0;
      ecnt_q <= '0;
      icnt_q <= '0;
      scnt_q <= '0;
    end else if (push_o) begin
      esum_q <= '0;
      isum_q <= '0;
      ssum_q <= '0;
      ecnt_q <= '0;
      icnt_q <= '0;
      scnt_q <= '0;
    end else begin
      esum_q <= esum_d;
      isum_q <= isum_d;
      ssum_q <= ssum_d;
      ecnt_q <= ecnt_d;
      icnt_q <= icnt_d;
      scnt_q <= scnt_d;
    end
  end

endmodule

// ===== hw/rtl/snli_div.sv =====
// Unsigned restoring divider producing one quotient bit per cycle.
module snli_div #(
  parameter int unsigned W = 61
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [W:0]    trial;
  logic          fits;

  assign trial  = {rem_q, quo_q[W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

endmodule

// ===== hw/rtl/snli_back.sv =====
// Back end: sequencer for averaging, shunting divide, leaky update and CORDIC activation.
module snli_back
  import snli_pkg::*;
#(
  parameter int unsigned SUM_W = 27,
  parameter int unsigned CNT_W = 11,
  localparam int unsigned REC_W = 3 * (SUM_W + CNT_W)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               rec_avail_i,
  input  logic [REC_W-1:0]   rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] activation_o,
  output logic signed [15:0] membrane_state_o
);
  localparam int unsigned PW    = 16 + SUM_W;
  localparam int unsigned DIV_W = SUM_W + 34;
  localparam int unsigned QW    = DIV_W + 1;
  localparam int unsigned AW    = PW + 2;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHAN = 5'd1;
  localparam logic [4:0] S_CDIV = 5'd2;
  localparam logic [4:0] S_MULE = 5'd3;
  localparam logic [4:0] S_MULS = 5'd4;
  localparam logic [4:0] S_MULI = 5'd5;
  localparam logic [4:0] S_DEN  = 5'd6;
  localparam logic [4:0] S_QDIV = 5'd7;
  localparam logic [4:0] S_A    = 5'd8;
  localparam logic [4:0] S_DIFF = 5'd9;
  localparam logic [4:0] S_LEAK = 5'd10;
  localparam logic [4:0] S_X    = 5'd11;
  localparam logic [4:0] S_COR  = 5'd12;
  localparam logic [4:0] S_MB   = 5'd13;
  localparam logic [4:0] S_MC   = 5'd14;
  localparam logic [4:0] S_ACT  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  localparam logic [1:0] CH_EXC   = 2'd0;
  localparam logic [1:0] CH_INH   = 2'd1;
  localparam logic [1:0] CH_SHUNT = 2'd2;

  localparam logic signed [PW:0] ONE_Q24 = (PW + 1)'(1) << 24;

  logic [4:0]              st_q, st_d;
  logic [1:0]              ch_q, ch_d;
  logic [REC_W-1:0]        rec_q;
  logic signed [SUM_W-1:0] esum, isum, ssum, csum, cmag;
  logic [CNT_W-1:0]        ecnt, icnt, scnt, ccnt;
  logic signed [SUM_W-1:0] e_q, e_d, i_q, i_d, s_q, s_d, cval;
  logic                    neg_q, neg_d;
  logic                    cval_we;

  logic signed [15:0]      mul_g;
  logic signed [SUM_W-1:0] mul_v;
  logic signed [PW-1:0]    prod, pe_q, ps_q, pi_q, pe_d, ps_d, pi_d, pe_mag;
  logic signed [PW:0]      den_full, den_pos;

  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_num, div_den, div_quot;
  logic signed [QW-1:0]    qs;
  logic signed [31:0]      ae_q, ae_d, a_q, a_d, x_q, x_d;
  logic signed [AW-1:0]    a_full;
  logic signed [32:0]      diff_q, diff_d;
  logic signed [49:0]      d_q, d_d;
  logic signed [34:0]      xs;

  logic signed [35:0]      cx_q, cx_d, cy_q, cy_d, shx, shy;
  logic signed [19:0]      z_q, z_d;
  logic [4:0]              it_q, it_d;
  logic signed [35:0]      t_q, t_d;
  logic signed [52:0]      u_q, u_d;
  logic signed [21:0]      av;
  logic signed [15:0]      act_q, act_d;
  logic signed [27:0]      xm;

  logic                    ov_q, ov_d;
  logic signed [15:0]      oact_q, oact_d, omem_q, omem_d;

  assign {esum, isum, ssum, ecnt, icnt, scnt} = rec_q;

  always_comb begin
    case (ch_q)
      CH_EXC: begin
        csum = esum;
        ccnt = ecnt;
      end
      CH_INH: begin
        csum = isum;
        ccnt = icnt;
      end
      default: begin
        csum = ssum;
        ccnt = scnt;
      end
    endcase
  end

  assign cmag = csum[SUM_W-1] ? -csum : csum;

  always_comb begin
    case (st_q)
      S_MULE: begin
        mul_g = cfg_i.phi;
        mul_v = e_q;
      end
      S_MULS: begin
        mul_g = cfg_i.psi;
        mul_v = s_q;
      end
      default: begin
        mul_g = cfg_i.chi;
        mul_v = i_q;
      end
    endcase
  end

  assign prod     = PW'(mul_g * mul_v);
  assign den_full = ONE_Q24 + $signed({ps_q[PW-1], ps_q});
  assign den_pos  = (den_full <= 0) ? (PW + 1)'(1) : den_full;
  assign pe_mag   = pe_q[PW-1] ? -pe_q : pe_q;
  assign qs       = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign a_full   = $signed(AW'(ae_q)) - $signed(AW'(pi_q >>> 8));
  assign xs       = $signed(35'(x_q)) + $signed(35'(d_q >>> 16));
  assign shx      = cx_q >>> it_q;
  assign shy      = cy_q >>> it_q;
  assign av       = $signed(22'(cfg_i.alpha)) + $signed(22'(u_q >>> 32));
  assign xm       = 28'(x_q >>> 4);

  always_comb begin
    st_d      = st_q;
    ch_d      = ch_q;
    e_d       = e_q;
    i_d       = i_q;
    s_d       = s_q;
    neg_d     = neg_q;
    pe_d      = pe_q;
    ps_d      = ps_q;
    pi_d      = pi_q;
    ae_d      = ae_q;
    a_d       = a_q;
    x_d       = x_q;
    diff_d    = diff_q;
    d_d       = d_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    z_d       = z_q;
    it_d      = it_q;
    t_d       = t_q;
    u_d       = u_q;
    act_d     = act_q;
    ov_d      = ov_q && out_stall_i;
    oact_d    = oact_q;
    omem_d    = omem_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = DIV_W'(cmag);
    div_den   = DIV_W'(ccnt);
    cval      = csum;
    cval_we   = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (rec_avail_i) begin
          pop_o = 1'b1;
          ch_d  = CH_EXC;
          st_d  = S_CHAN;
        end
      end
      S_CHAN: begin
        if (!cfg_i.avg) begin
          cval_we = 1'b1;
        end else if (ccnt == '0) begin
          cval    = '0;
          cval_we = 1'b1;
        end else begin
          div_start = 1'b1;
          neg_d     = csum[SUM_W-1];
          st_d      = S_CDIV;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          cval    = neg_q ? -$signed(div_quot[SUM_W-1:0]) : $signed(div_quot[SUM_W-1:0]);
          cval_we = 1'b1;
        end
      end
      S_MULE: begin
        pe_d = prod;
        st_d = S_MULS;
      end
      S_MULS: begin
        ps_d = prod;
        st_d = S_MULI;
      end
      S_MULI: begin
        pi_d = prod;
        st_d = S_DEN;
      end
      S_DEN: begin
        div_start = 1'b1;
        div_num   = DIV_W'({pe_mag, 16'b0});
        div_den   = DIV_W'($unsigned(den_pos));
        neg_d     = pe_q[PW-1];
        st_d      = S_QDIV;
      end
      S_QDIV: begin
        if (div_done) begin
          if (qs[QW-1:31] != {(QW - 31){qs[31]}}) begin
            ae_d = qs[QW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            ae_d = qs[31:0];
          end
          st_d = S_A;
        end
      end
      S_A: begin
        if (a_full[AW-1:31] != {(AW - 31){a_full[31]}}) begin
          a_d = a_full[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          a_d = a_full[31:0];
        end
        st_d = S_DIFF;
      end
      S_DIFF: begin
        diff_d = $signed(33'(a_q)) - $signed(33'(x_q));
        st_d   = S_LEAK;
      end
      S_LEAK: begin
        d_d  = 50'(diff_q * $signed({1'b0, cfg_i.leak}));
        st_d = S_X;
      end
      S_X: begin
        if (xs[34:31] != {4{xs[31]}}) begin
          x_d = xs[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          x_d = xs[31:0];
        end
        if (x_d[31]) begin
          act_d = '0;
          st_d  = S_OUT;
        end else begin
          cx_d = 36'sd65536;
          cy_d = 36'(x_d);
          z_d  = '0;
          it_d = '0;
          st_d = S_COR;
        end
      end
      S_COR: begin
        if (cy_q > 0) begin
          cx_d = cx_q + shy;
          cy_d = cy_q - shx;
          z_d  = z_q + $signed(20'(atan_lut(it_q)));
        end else if (cy_q < 0) begin
          cx_d = cx_q - shy;
          cy_d = cy_q + shx;
          z_d  = z_q - $signed(20'(atan_lut(it_q)));
        end
        it_d = it_q + 1'b1;
        if (it_q == 5'(CordicIters - 1)) begin
          st_d = S_MB;
        end
      end
      S_MB: begin
        t_d  = 36'(cfg_i.beta * z_q);
        st_d = S_MC;
      end
      S_MC: begin
        u_d  = 53'(t_q * $signed({1'b0, INV_TAN1}));
        st_d = S_ACT;
      end
      S_ACT: begin
        if (av[21:15] != {7{av[15]}}) begin
          act_d = av[21] ? 16'sh8000 : 16'sh7fff;
        end else begin
          act_d = av[15:0];
        end
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d   = 1'b1;
          oact_d = act_q;
          if (xm[27:15] != {13{xm[15]}}) begin
            omem_d = xm[27] ? 16'sh8000 : 16'sh7fff;
          end else begin
            omem_d = xm[15:0];
          end
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
    if (cval_we) begin
      case (ch_q)
        CH_EXC:  e_d = cval;
        CH_INH:  i_d = cval;
        default: s_d = cval;
      endcase
      if (ch_q == CH_SHUNT) begin
        st_d = S_MULE;
      end else begin
        ch_d = ch_q + 1'b1;
        st_d = S_CHAN;
      end
    end
  end

  snli_div #(
    .W(DIV_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ch_q <= CH_EXC;
      x_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ch_q <= ch_d;
      x_q  <= x_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
    e_q    <= e_d;
    i_q    <= i_d;
    s_q    <= s_d;
    neg_q  <= neg_d;
    pe_q   <= pe_d;
    ps_q   <= ps_d;
    pi_q   <= pi_d;
    ae_q   <= ae_d;
    a_q    <= a_d;
    diff_q <= diff_d;
    d_q    <= d_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    z_q    <= z_d;
    it_q   <= it_d;
    t_q    <= t_d;
    u_q    <= u_d;
    act_q  <= act_d;
    oact_q <= oact_d;
    omem_q <= omem_d;
  end

  assign out_valid_o      = ov_q;
  assign activation_o     = oact_q;
  assign membrane_state_o = omem_q;

endmodule

// ===== hw/rtl/shunting_leaky_integrator_neuron.sv =====
// Top level of the shunting leaky integrator neuron.
//
// Elements of the excitation, inhibition and shunting vectors arrive as input
// beats, one per cycle, each with its own valid flag; the beat that carries
// tick_last closes the tick. The front accumulates sums and counts at one beat
// per cycle and stalls only when its two-entry record queue is full.
// Each closed tick produces one output beat with the activation and the updated
// membrane state. The back works on one tick at a time; its time is set by the
// serial divider (one division for the shunting quotient and one more per
// non-empty channel when averaging) and the 17-step CORDIC, which is skipped
// when the membrane goes negative.
// Configuration beats are taken at any time (ready is held high) but should be
// written only while the block is idle.
// Reset clears the accumulators, the membrane and the queue and loads the
// register defaults. While the receiver stalls, the output beat holds, the back
// waits with its next result and the queue fills before the input stalls.
module shunting_leaky_integrator_neuron
  import snli_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] exc_value_i,
  input  logic               exc_valid_i,
  input  logic signed [15:0] inh_value_i,
  input  logic               inh_valid_i,
  input  logic signed [15:0] shunt_value_i,
  input  logic               shunt_valid_i,
  input  logic               tick_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] activation_o,
  output logic signed [15:0] membrane_state_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SUM_W = 16 + CNT_W;
  localparam int unsigned REC_W = 3 * (SUM_W + CNT_W);

  cfg_t             cfg_q;
  logic             accept, push, pop, empty, full;
  logic [REC_W-1:0] rec_in, rec_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha <= ALPHA_RST;
      cfg_q.beta  <= GAIN_RST;
      cfg_q.phi   <= GAIN_RST;
      cfg_q.chi   <= GAIN_RST;
      cfg_q.psi   <= GAIN_RST;
      cfg_q.leak  <= LEAK_RST;
      cfg_q.avg   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ALPHA: cfg_q.alpha <= cfg_data_i;
        REG_BETA:  cfg_q.beta  <= cfg_data_i;
        REG_PHI:   cfg_q.phi   <= cfg_data_i;
        REG_CHI:   cfg_q.chi   <= cfg_data_i;
        REG_PSI:   cfg_q.psi   <= cfg_data_i;
        REG_LEAK:  cfg_q.leak  <= cfg_data_i;
        REG_AVG:   cfg_q.avg   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  snli_front #(
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .exc_value_i  (exc_value_i),
    .exc_valid_i  (exc_valid_i),
    .inh_value_i  (inh_value_i),
    .inh_valid_i  (inh_valid_i),
    .shunt_value_i(shunt_value_i),
    .shunt_valid_i(shunt_valid_i),
    .tick_last_i  (tick_last_i),
    .push_o       (push),
    .rec_o        (rec_in)
  );

  snli_fifo #(
    .WIDTH(REC_W),
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rec_in),
    .pop_i  (pop),
    .data_o (rec_out),
    .empty_o(empty),
    .full_o (full)
  );

  snli_back #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .rec_avail_i     (!empty),
    .rec_i           (rec_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .activation_o    (activation_o),
    .membrane_state_o(membrane_state_o)
  );

endmodule

// ===== dv/snli_checker.sv =====
// Scoreboard for the shunting leaky integrator neuron: predicts each output beat and compares it.
`timescale 1ns / 100ps
module snli_checker
  import snli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] exc_value_i,
  input  logic               exc_valid_i,
  input  logic signed [15:0] inh_value_i,
  input  logic               inh_valid_i,
  input  logic signed [15:0] shunt_value_i,
  input  logic               shunt_valid_i,
  input  logic               tick_last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] activation_i,
  input  logic signed [15:0] membrane_state_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct {
    logic signed [15:0] act;
    logic signed [15:0] mem;
  } neuron_beat_t;

  localparam longint Int32Min = -64'sd2147483648;
  localparam longint Int32Max = 64'sd2147483647;

  cfg_t         regs;
  longint       membrane;
  longint       exc_sum, inh_sum, shunt_sum;
  int unsigned  exc_cnt, inh_cnt, shunt_cnt;
  neuron_beat_t expected_beats[$];
  longint       arctan_step[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                                    128, 64, 32, 16, 8, 4, 2, 1};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint level(longint sum, int unsigned cnt, logic avg);
    if (!avg) return sum;
    if (cnt == 0) return 0;
    return sum / longint'(cnt);
  endfunction

  function automatic longint arctan_q16(longint x);
    longint cx, cy, z, nx;
    cx = 65536;
    cy = x;
    z  = 0;
    for (int i = 0; i < 17; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += arctan_step[i];
        cx = nx;
      end else if (cy < 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= arctan_step[i];
        cx = nx;
      end
    end
    return z;
  endfunction

  task automatic gather(inout longint sum, inout int unsigned cnt, input logic signed [15:0] v,
                        input logic ok);
    if (ok && cnt < MaxElementsDef) begin
      sum += longint'(v);
      cnt++;
    end
  endtask

  task automatic close_tick();
    longint e, ih, sh, den, ae, a, d, act, mem;
    neuron_beat_t beat;
    e  = level(exc_sum, exc_cnt, regs.avg);
    ih = level(inh_sum, inh_cnt, regs.avg);
    sh = level(shunt_sum, shunt_cnt, regs.avg);
    den = 64'sd16777216 + longint'(regs.psi) * sh;
    if (den <= 0) den = 1;
    ae = clip((longint'(regs.phi) * e * 65536) / den, Int32Min, Int32Max);
    a  = clip(ae - ((longint'(regs.chi) * ih) >>> 8), Int32Min, Int32Max);
    d  = (a - membrane) * longint'(regs.leak);
    membrane = clip(membrane + (d >>> 16), Int32Min, Int32Max);
    if (membrane < 0) begin
      act = 0;
    end else begin
      act = longint'(regs.alpha)
          + ((longint'(regs.beta) * arctan_q16(membrane) * longint'(INV_TAN1)) >>> 32);
      act = clip(act, -32768, 32767);
    end
    mem = clip(membrane >>> 4, -32768, 32767);
    beat.act = act[15:0];
    beat.mem = mem[15:0];
    expected_beats.push_back(beat);
    exc_sum = 0;
    inh_sum = 0;
    shunt_sum = 0;
    exc_cnt = 0;
    inh_cnt = 0;
    shunt_cnt = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_beat_t want;
    if (!rst_ni) begin
      regs = '{alpha: ALPHA_RST, beta: GAIN_RST, phi: GAIN_RST, chi: GAIN_RST,
               psi: GAIN_RST, leak: LEAK_RST, avg: 1'b0};
      membrane = 0;
      exc_sum = 0;
      inh_sum = 0;
      shunt_sum = 0;
      exc_cnt = 0;
      inh_cnt = 0;
      shunt_cnt = 0;
      expected_beats.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ALPHA: regs.alpha = cfg_data_i;
          REG_BETA:  regs.beta  = cfg_data_i;
          REG_PHI:   regs.phi   = cfg_data_i;
          REG_CHI:   regs.chi   = cfg_data_i;
          REG_PSI:   regs.psi   = cfg_data_i;
          REG_LEAK:  regs.leak  = cfg_data_i;
          REG_AVG:   regs.avg   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: output beat with none expected: activation %0d, membrane %0d",
                   $time, activation_i, membrane_state_i);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          if (activation_i !== want.act) begin
            $display("%0t: activation mismatch: expected %0d, actual %0d",
                     $time, want.act, activation_i);
            fail_count_o++;
          end
          if (membrane_state_i !== want.mem) begin
            $display("%0t: membrane_state mismatch: expected %0d, actual %0d",
                     $time, want.mem, membrane_state_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        gather(exc_sum, exc_cnt, exc_value_i, exc_valid_i);
        gather(inh_sum, inh_cnt, inh_value_i, inh_valid_i);
        gather(shunt_sum, shunt_cnt, shunt_value_i, shunt_valid_i);
        if (tick_last_i) close_tick();
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ===== dv/shunting_leaky_integrator_neuron_tb.sv =====
// Testbench top for the shunting leaky integrator neuron: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module shunting_leaky_integrator_neuron_tb
  import snli_pkg::*;
;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned SettleCycles = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] exc_value = '0;
  logic               exc_valid = 1'b0;
  logic signed [15:0] inh_value = '0;
  logic               inh_valid = 1'b0;
  logic signed [15:0] shunt_value = '0;
  logic               shunt_valid = 1'b0;
  logic               tick_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] activation;
  logic signed [15:0] membrane_state;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_ALPHA;
  logic [15:0]        cfg_data = '0;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        beats_in = 0;
  bit                 calm = 1'b0;

  shunting_leaky_integrator_neuron u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .exc_value_i      (exc_value),
    .exc_valid_i      (exc_valid),
    .inh_value_i      (inh_value),
    .inh_valid_i      (inh_valid),
    .shunt_value_i    (shunt_value),
    .shunt_valid_i    (shunt_valid),
    .tick_last_i      (tick_last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .activation_o     (activation),
    .membrane_state_o (membrane_state),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  snli_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .exc_value_i      (exc_value),
    .exc_valid_i      (exc_valid),
    .inh_value_i      (inh_value),
    .inh_valid_i      (inh_valid),
    .shunt_value_i    (shunt_value),
    .shunt_valid_i    (shunt_valid),
    .tick_last_i      (tick_last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .activation_i     (activation),
    .membrane_state_i (membrane_state),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, and once holds off long enough for the input to back up.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && beats_in >= 200) begin
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        held = 1'b1;
      end
      out_stall = !calm && ($urandom_range(0, 99) < 9);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WatchdogLimit) begin
        $display("shunting_leaky_integrator_neuron test failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 4096)) - 16'd2048;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 256)) - 16'd128;
    endcase
  endfunction

  task automatic send(input logic [15:0] e, input logic ev, input logic [15:0] i,
                      input logic iv, input logic [15:0] s, input logic sv, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    exc_value   = e;
    exc_valid   = ev;
    inh_value   = i;
    inh_valid   = iv;
    shunt_value = s;
    shunt_valid = sv;
    tick_last   = last;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
  endtask

  task automatic send_random(input logic last);
    send(pick_element(), $urandom_range(0, 9) < 8, pick_element(), $urandom_range(0, 9) < 8,
         pick_element(), $urandom_range(0, 9) < 8, last);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] alpha, input logic [15:0] beta,
                           input logic [15:0] phi, input logic [15:0] chi,
                           input logic [15:0] psi, input logic [15:0] leak,
                           input logic [15:0] avg);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
    write_reg(REG_PHI, phi);
    write_reg(REG_CHI, chi);
    write_reg(REG_PSI, psi);
    write_reg(REG_LEAK, leak);
    write_reg(REG_AVG, avg);
  endtask

  initial begin
    int unsigned sent, len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 3);
      if (phase == 1) begin
        load_regs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
      end else if (phase == 2) begin
        load_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      end else if (phase == 4) begin
        load_regs(16'd0, 16'd4096, 16'd4096, 16'd2048, 16'd256, 16'd32768, 16'd1);
      end else if (phase > 2) begin
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
      end

      if (phase == 0) begin
        send(16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 1'b1);
        send(16'h7fff, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0);
        send(16'h7fff, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1);
        send(16'h8000, 1'b1, 16'h8000, 1'b1, 16'h8000, 1'b1, 1'b1);
        send(16'd0, 1'b0, 16'h7fff, 1'b1, 16'd0, 1'b0, 1'b1);
        send(16'd0, 1'b0, 16'h7fff, 1'b1, 16'd0, 1'b0, 1'b1);
        send(16'd0, 1'b0, 16'd0, 1'b0, 16'h7fff, 1'b1, 1'b1);
        send(16'hffff, 1'b1, 16'hffff, 1'b1, 16'hffff, 1'b1, 1'b1);
        send(16'h1234, 1'b0, 16'h5678, 1'b0, 16'h9abc, 1'b0, 1'b0);
        send(16'd4096, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1);
      end else if (phase == 1) begin
        send(16'd100, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1);
        send(16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1);
        send(16'h7fff, 1'b1, 16'h7fff, 1'b1, 16'h7fff, 1'b1, 1'b1);
      end else if (phase == 2) begin
        send(16'd0, 1'b0, 16'd0, 1'b0, 16'h7fff, 1'b1, 1'b1);
        send(16'h7fff, 1'b1, 16'd0, 1'b0, 16'h7fff, 1'b1, 1'b1);
        send(16'h8000, 1'b1, 16'h8000, 1'b1, 16'd1000, 1'b1, 1'b1);
      end

      if (phase == 5) begin
        for (int k = 0; k < 1030; k++) begin
          send(16'($urandom_range(0, 512)) - 16'd256, 1'b1, 16'($urandom_range(0, 512)),
               1'b1, 16'($urandom_range(0, 256)), 1'b1, k == 1029);
        end
      end

      sent = 0;
      while (sent < 55) begin
        len = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
          send(pick_element(), 1'b0, pick_element(), 1'b0, pick_element(), 1'b0, 1'b0);
        end
        for (int k = 0; k < len; k++) begin
          send_random(k == len - 1);
        end
        sent += len;
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("shunting_leaky_integrator_neuron test passed");
    end else begin
      $display("shunting_leaky_integrator_neuron test failed");
    end
    $finish;
  end

endmodule
